>>> rtl/sskmv_pkg.sv
// Shared constants, types and a helper function of the sketch bucket engine.
// Depends on nothing; the divider, the top level and the testbench refer to it by scoped names.

package sskmv_pkg;

    // Sketch geometry and list depth.
    localparam int ROWS    = 4;
    localparam int COLUMNS = 1024;
    localparam int K_MAX   = 32;

    // Field widths.
    localparam int ROW_W  = 2;
    localparam int COL_W  = 10;
    localparam int KEY_W  = 32;
    localparam int EDGE_W = 64;
    localparam int HASH_W = 32;
    localparam int LVL_W  = 7;
    localparam int EST_W  = 31;
    localparam int CFG_W  = 6;

    // Derived widths and depths.
    localparam int BKT_W    = ROW_W + COL_W;
    localparam int BUCKETS  = ROWS * COLUMNS;
    localparam int IDX_W    = $clog2(K_MAX);
    localparam int CNT_W    = $clog2(K_MAX + 1);
    localparam int LIST_AW  = BKT_W + IDX_W;
    localparam int LIST_DEP = BUCKETS * K_MAX;
    localparam int DIVD_W   = IDX_W + HASH_W;

    // Reset value of the list size register and the estimate ceiling.
    localparam logic [CFG_W-1:0] KMV_SIZE_RESET = CFG_W'(32);
    localparam logic [EST_W-1:0] EST_SAT        = {EST_W{1'b1}};

    // One bucket record: level, candidate key and list fill.
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] fill;
    } bucket_t;

    localparam int BUCKET_W = $bits(bucket_t);

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BRD,
        ST_BCHK,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_VWRITE,
        ST_EST,
        ST_DIV,
        ST_DONE
    } state_t;

    // Number of trailing one bits of the edge hash (0 to 64).
    function automatic logic [LVL_W-1:0] trailing_ones(input logic [EDGE_W-1:0] e);
        logic [EDGE_W-1:0] low;
        logic [LVL_W-1:0]  idx;
        low = ~e & (e + EDGE_W'(1));
        idx = '0;
        for (int i = 0; i < EDGE_W; i++)
        begin
            if (low[i])
            begin
                idx = idx | LVL_W'(i);
            end
        end
        if (low == '0)
        begin
            idx = LVL_W'(EDGE_W);
        end
        return idx;
    endfunction

endpackage

>>> rtl/sskmv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.

module sskmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sskmv_div.sv
// Bit-serial restoring divider for the cardinality estimate, one quotient bit per cycle.
// Depends on sskmv_pkg for widths and the saturation ceiling.

module sskmv_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sskmv_pkg::DIVD_W-1:0]   dividend,
    input  logic [sskmv_pkg::HASH_W-1:0]   divisor,
    output logic                           done,
    output logic [sskmv_pkg::EST_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(sskmv_pkg::DIVD_W + 1);

    logic [sskmv_pkg::HASH_W-1:0] rem_reg, rem_next;
    logic [sskmv_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [sskmv_pkg::HASH_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [sskmv_pkg::HASH_W:0]   trial;
    logic [sskmv_pkg::HASH_W:0]   diff;

    // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[sskmv_pkg::DIVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[sskmv_pkg::HASH_W-1:0];
                quo_next = {quo_reg[sskmv_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[sskmv_pkg::HASH_W-1:0];
                quo_next = {quo_reg[sskmv_pkg::DIVD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(sskmv_pkg::DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    // Saturate quotients that do not fit the estimate width.
    assign done     = done_reg;
    assign quotient = (|quo_reg[sskmv_pkg::DIVD_W-1:sskmv_pkg::EST_W]) ?
                      sskmv_pkg::EST_SAT : quo_reg[sskmv_pkg::EST_W-1:0];

endmodule

>>> rtl/spread_sketch_kmv_update.sv
// Per word: bucket read and level rule, a scan of the descending list, for an update the shift
// moves (one list memory read and write per cycle), and the serial divider for the estimate when
// the list is full and its head is not zero.
// One word is in flight at a time; the next can enter in the cycle after a result is handed on.
// Reset: a clearing pass zeroes every bucket record in the bucket memory; no input word is taken
// during it. The list size register resets to 32.

module spread_sketch_kmv_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [sskmv_pkg::ROW_W-1:0]   row,
    input  logic [sskmv_pkg::COL_W-1:0]   column,
    input  logic [sskmv_pkg::KEY_W-1:0]   src_key,
    input  logic [sskmv_pkg::EDGE_W-1:0]  edge_hash,
    input  logic [sskmv_pkg::HASH_W-1:0]  dst_hash,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sskmv_pkg::EST_W-1:0]   estimate,
    output logic [sskmv_pkg::KEY_W-1:0]   bucket_key,
    output logic [sskmv_pkg::LVL_W-1:0]   bucket_level,
    output logic                          value_inserted,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sskmv_pkg::CFG_W-1:0]   kmv_size
);

    localparam int CNT_W = sskmv_pkg::CNT_W;
    localparam int IDX_W = sskmv_pkg::IDX_W;

    sskmv_pkg::state_t state_reg, state_next;

    logic [sskmv_pkg::BKT_W-1:0]  clr_reg, clr_next;
    logic [sskmv_pkg::CFG_W-1:0]  k_reg;
    logic                         func_reg, func_next;
    logic [sskmv_pkg::BKT_W-1:0]  bkt_reg, bkt_next;
    logic [sskmv_pkg::KEY_W-1:0]  src_reg, src_next;
    logic [sskmv_pkg::LVL_W-1:0]  elvl_reg, elvl_next;
    logic [sskmv_pkg::HASH_W-1:0] dst_reg, dst_next;
    logic [sskmv_pkg::LVL_W-1:0]  lvl_reg, lvl_next;
    logic [sskmv_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic [CNT_W-1:0]             c_reg, c_next;
    logic                         dup_reg, dup_next;
    logic [sskmv_pkg::HASH_W-1:0] a0_reg, a0_next;
    logic [sskmv_pkg::HASH_W-1:0] a1_reg, a1_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]             chk_reg, chk_next;
    logic [CNT_W-1:0]             mv_reg, mv_next;
    logic                         dn_reg, dn_next;
    logic                         ins_reg, ins_next;
    logic [CNT_W-1:0]             nfill_reg, nfill_next;
    logic [sskmv_pkg::HASH_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]             tgt_reg, tgt_next;
    logic [sskmv_pkg::EST_W-1:0]  est_reg, est_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sskmv_pkg::EST_W-1:0]  o_est_reg, o_est_next;
    logic [sskmv_pkg::KEY_W-1:0]  o_key_reg, o_key_next;
    logic [sskmv_pkg::LVL_W-1:0]  o_lvl_reg, o_lvl_next;
    logic                         o_ins_reg, o_ins_next;

    // Memory and divider hookup.
    logic                             b_we;
    logic [sskmv_pkg::BKT_W-1:0]      b_waddr;
    sskmv_pkg::bucket_t               b_wdata;
    logic [sskmv_pkg::BUCKET_W-1:0]   b_rdata_raw;
    sskmv_pkg::bucket_t               b_rdata;
    logic                             l_we;
    logic [sskmv_pkg::LIST_AW-1:0]    l_waddr;
    logic [sskmv_pkg::HASH_W-1:0]     l_wdata;
    logic [sskmv_pkg::LIST_AW-1:0]    l_raddr;
    logic [sskmv_pkg::HASH_W-1:0]     l_rdata;
    logic                             div_start;
    logic                             div_done;
    logic [sskmv_pkg::EST_W-1:0]      div_q;
    logic [sskmv_pkg::DIVD_W-1:0]     dividend;

    // Effective list size and the multiplier of the estimate.
    logic [CNT_W-1:0] k_eff;
    logic [IDX_W-1:0] m_val;
    logic [CNT_W-1:0] n_cur;
    logic [CNT_W-1:0] n_rd;
    logic             full;
    logic [sskmv_pkg::HASH_W-1:0] entry;

    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (CNT_W'(k_reg) > CNT_W'(sskmv_pkg::K_MAX))
        begin
            k_eff = CNT_W'(sskmv_pkg::K_MAX);
        end
        else
        begin
            k_eff = CNT_W'(k_reg);
        end
        m_val = (k_eff > CNT_W'(1)) ? IDX_W'(k_eff - CNT_W'(1)) : IDX_W'(1);
        n_cur = (fill_reg > CNT_W'(sskmv_pkg::K_MAX)) ? CNT_W'(sskmv_pkg::K_MAX) : fill_reg;
        n_rd  = (b_rdata.fill > CNT_W'(sskmv_pkg::K_MAX)) ?
                CNT_W'(sskmv_pkg::K_MAX) : b_rdata.fill;
        full  = (fill_reg >= k_eff);
        entry = l_rdata;
    end

    // m * (2^32 - 1) written as a shift and a subtract.
    assign dividend = {m_val, {sskmv_pkg::HASH_W{1'b0}}} - sskmv_pkg::DIVD_W'(m_val);

    assign b_rdata = sskmv_pkg::bucket_t'(b_rdata_raw);

    sskmv_ram #(
        .WIDTH (sskmv_pkg::BUCKET_W),
        .DEPTH (sskmv_pkg::BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (bkt_reg),
        .rdata (b_rdata_raw)
    );

    sskmv_ram #(
        .WIDTH (sskmv_pkg::HASH_W),
        .DEPTH (sskmv_pkg::LIST_DEP)
    ) u_list_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    sskmv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (head_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer: next state, memory accesses and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        bkt_next       = bkt_reg;
        src_next       = src_reg;
        elvl_next      = elvl_reg;
        dst_next       = dst_reg;
        lvl_next       = lvl_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        c_next         = c_reg;
        dup_next       = dup_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = rd_vld_reg;
        chk_next       = chk_reg;
        mv_next        = mv_reg;
        dn_next        = dn_reg;
        ins_next       = ins_reg;
        nfill_next     = nfill_reg;
        head_next      = head_reg;
        tgt_next       = tgt_reg;
        est_next       = est_reg;
        o_est_next     = o_est_reg;
        o_key_next     = o_key_reg;
        o_lvl_next     = o_lvl_reg;
        o_ins_next     = o_ins_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        b_we           = 1'b0;
        b_waddr        = bkt_reg;
        b_wdata        = '{level: lvl_reg, key: key_reg, fill: nfill_reg};
        l_we           = 1'b0;
        l_waddr        = {bkt_reg, tgt_reg};
        l_wdata        = dst_reg;
        l_raddr        = {bkt_reg, rd_idx_reg[IDX_W-1:0]};
        div_start      = 1'b0;

        // The output register empties when its word is taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sskmv_pkg::ST_CLEAR:
            begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                b_wdata  = '0;
                clr_next = clr_reg + sskmv_pkg::BKT_W'(1);
                if (clr_reg == sskmv_pkg::BKT_W'(sskmv_pkg::BUCKETS - 1))
                begin
                    state_next = sskmv_pkg::ST_IDLE;
                end
            end

            sskmv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next  = func;
                    bkt_next   = {row, column};
                    src_next   = src_key;
                    elvl_next  = sskmv_pkg::trailing_ones(edge_hash);
                    dst_next   = dst_hash;
                    state_next = sskmv_pkg::ST_BRD;
                end
            end

            sskmv_pkg::ST_BRD:
            begin
                state_next = sskmv_pkg::ST_BCHK;
            end

            // Bucket record is available; apply the level rule and start the scan of a non-empty list.
            sskmv_pkg::ST_BCHK:
            begin
                if (!func_reg && (b_rdata.level < elvl_reg))
                begin
                    lvl_next = elvl_reg;
                    key_next = src_reg;
                end
                else
                begin
                    lvl_next = b_rdata.level;
                    key_next = b_rdata.key;
                end
                fill_next   = b_rdata.fill;
                c_next      = '0;
                dup_next    = 1'b0;
                rd_idx_next = '0;
                rd_vld_next = 1'b0;
                if (n_rd == '0)
                begin
                    state_next = sskmv_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = sskmv_pkg::ST_SCAN;
                end
            end

            // Walk the descending list, counting entries above the new value.
            sskmv_pkg::ST_SCAN:
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                rd_vld_next = 1'b1;
                chk_next    = rd_idx_reg;
                if (rd_vld_reg)
                begin
                    if (chk_reg == CNT_W'(0))
                    begin
                        a0_next = entry;
                    end
                    if (chk_reg == CNT_W'(1))
                    begin
                        a1_next = entry;
                    end
                    if (entry > dst_reg)
                    begin
                        c_next = c_reg + CNT_W'(1);
                        if (chk_reg == n_cur - CNT_W'(1))
                        begin
                            rd_vld_next = 1'b0;
                            state_next  = sskmv_pkg::ST_DECIDE;
                        end
                    end
                    else
                    begin
                        dup_next    = (entry == dst_reg);
                        rd_vld_next = 1'b0;
                        state_next  = sskmv_pkg::ST_DECIDE;
                    end
                end
            end

            // Choose between dropping the head, inserting in place, or no change.
            sskmv_pkg::ST_DECIDE:
            begin
                ins_next    = 1'b0;
                nfill_next  = fill_reg;
                head_next   = a0_reg;
                mv_next     = '0;
                rd_vld_next = 1'b0;
                if (!func_reg)
                begin
                    if (full)
                    begin
                        if ((c_reg != '0) && !dup_reg)
                        begin
                            ins_next    = 1'b1;
                            tgt_next    = IDX_W'(c_reg - CNT_W'(1));
                            head_next   = (c_reg >= CNT_W'(2)) ? a1_reg : dst_reg;
                            mv_next     = c_reg - CNT_W'(1);
                            rd_idx_next = CNT_W'(1);
                            dn_next     = 1'b0;
                        end
                    end
                    else if (!dup_reg)
                    begin
                        ins_next    = 1'b1;
                        tgt_next    = IDX_W'(c_reg);
                        head_next   = (c_reg == '0) ? dst_reg : a0_reg;
                        mv_next     = n_cur - c_reg;
                        rd_idx_next = n_cur - CNT_W'(1);
                        dn_next     = 1'b1;
                        nfill_next  = n_cur + CNT_W'(1);
                    end
                end
                if (func_reg)
                begin
                    state_next = sskmv_pkg::ST_EST;
                end
                else
                begin
                    state_next = sskmv_pkg::ST_SHIFT;
                end
            end

            // Move entries one place, one read and one write per cycle.
            sskmv_pkg::ST_SHIFT:
            begin
                rd_vld_next = 1'b0;
                if (mv_reg != '0)
                begin
                    rd_idx_next = dn_reg ? rd_idx_reg - CNT_W'(1) : rd_idx_reg + CNT_W'(1);
                    mv_next     = mv_reg - CNT_W'(1);
                    rd_vld_next = 1'b1;
                    chk_next    = rd_idx_reg;
                end
                if (rd_vld_reg)
                begin
                    l_we    = 1'b1;
                    l_waddr = {bkt_reg, dn_reg ? IDX_W'(chk_reg + CNT_W'(1))
                                               : IDX_W'(chk_reg - CNT_W'(1))};
                    l_wdata = entry;
                end
                if (mv_reg == '0)
                begin
                    state_next = sskmv_pkg::ST_VWRITE;
                end
            end

            // Place the new value if it is inserted, and write the bucket record back.
            sskmv_pkg::ST_VWRITE:
            begin
                l_we       = ins_reg;
                b_we       = 1'b1;
                state_next = sskmv_pkg::ST_EST;
            end

            sskmv_pkg::ST_EST:
            begin
                if (nfill_reg < k_eff)
                begin
                    est_next   = sskmv_pkg::EST_W'(nfill_reg);
                    state_next = sskmv_pkg::ST_DONE;
                end
                else if (head_reg == '0)
                begin
                    est_next   = sskmv_pkg::EST_SAT;
                    state_next = sskmv_pkg::ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = sskmv_pkg::ST_DIV;
                end
            end

            sskmv_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    est_next   = div_q;
                    state_next = sskmv_pkg::ST_DONE;
                end
            end

            // Hand the word to the output register once it is free.
            sskmv_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    o_est_next     = est_reg;
                    o_key_next     = key_reg;
                    o_lvl_next     = lvl_reg;
                    o_ins_next     = ins_reg;
                    out_valid_next = 1'b1;
                    state_next     = sskmv_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sskmv_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sskmv_pkg::ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= sskmv_pkg::KMV_SIZE_RESET;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            if (cfg_valid)
            begin
                k_reg <= kmv_size;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        bkt_reg    <= bkt_next;
        src_reg    <= src_next;
        elvl_reg   <= elvl_next;
        dst_reg    <= dst_next;
        lvl_reg    <= lvl_next;
        key_reg    <= key_next;
        fill_reg   <= fill_next;
        c_reg      <= c_next;
        dup_reg    <= dup_next;
        a0_reg     <= a0_next;
        a1_reg     <= a1_next;
        rd_idx_reg <= rd_idx_next;
        chk_reg    <= chk_next;
        mv_reg     <= mv_next;
        dn_reg     <= dn_next;
        ins_reg    <= ins_next;
        nfill_reg  <= nfill_next;
        head_reg   <= head_next;
        tgt_reg    <= tgt_next;
        est_reg    <= est_next;
        o_est_reg  <= o_est_next;
        o_key_reg  <= o_key_next;
        o_lvl_reg  <= o_lvl_next;
        o_ins_reg  <= o_ins_next;
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign estimate       = o_est_reg;
    assign bucket_key     = o_key_reg;
    assign bucket_level   = o_lvl_reg;
    assign value_inserted = o_ins_reg;

endmodule

>>> bench/spread_sketch_kmv_update_tb.sv
// Testbench for the sketch bucket engine spread_sketch_kmv_update.
// It keeps its own model of the bucket state to predict every result word.
// Depends on sskmv_pkg and the top level RTL.

module spread_sketch_kmv_update_tb;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_PROBE  = 1'b1;

    typedef struct packed {
        logic [sskmv_pkg::EST_W-1:0] estimate;
        logic [sskmv_pkg::KEY_W-1:0] key;
        logic [sskmv_pkg::LVL_W-1:0] level;
        logic                        inserted;
    } bucket_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           func;
    logic [sskmv_pkg::ROW_W-1:0]    row;
    logic [sskmv_pkg::COL_W-1:0]    column;
    logic [sskmv_pkg::KEY_W-1:0]    src_key;
    logic [sskmv_pkg::EDGE_W-1:0]   edge_hash;
    logic [sskmv_pkg::HASH_W-1:0]   dst_hash;
    logic                           out_valid;
    logic                           out_ready;
    logic [sskmv_pkg::EST_W-1:0]    estimate;
    logic [sskmv_pkg::KEY_W-1:0]    bucket_key;
    logic [sskmv_pkg::LVL_W-1:0]    bucket_level;
    logic                           value_inserted;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sskmv_pkg::CFG_W-1:0]    kmv_size;

    // Model of the bucket memories and the list size register.
    logic [sskmv_pkg::LVL_W-1:0]    lvl_mem [sskmv_pkg::BUCKETS];
    logic [sskmv_pkg::KEY_W-1:0]    key_mem [sskmv_pkg::BUCKETS];
    int unsigned                    fill_mem [sskmv_pkg::BUCKETS];
    logic [sskmv_pkg::HASH_W-1:0]   min_list [sskmv_pkg::BUCKETS*sskmv_pkg::K_MAX];
    logic [sskmv_pkg::CFG_W-1:0]    list_size;

    bucket_result_t      pending_results [$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    spread_sketch_kmv_update i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .row            (row),
        .column         (column),
        .src_key        (src_key),
        .edge_hash      (edge_hash),
        .dst_hash       (dst_hash),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .estimate       (estimate),
        .bucket_key     (bucket_key),
        .bucket_level   (bucket_level),
        .value_inserted (value_inserted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .kmv_size       (kmv_size)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    // Effective list size: zero counts as one, large values clamp.
    function automatic int unsigned eff_size();
        int unsigned k;
        k = list_size;
        if (k == 0)
        begin
            k = 1;
        end
        if (k > sskmv_pkg::K_MAX)
        begin
            k = sskmv_pkg::K_MAX;
        end
        return k;
    endfunction

    // Updates the model bucket for one word and returns the expected result.
    function automatic bucket_result_t bucket_model_step(
            input logic f, input logic [sskmv_pkg::ROW_W-1:0] r,
            input logic [sskmv_pkg::COL_W-1:0] c,
            input logic [sskmv_pkg::KEY_W-1:0] src,
            input logic [sskmv_pkg::EDGE_W-1:0] e,
            input logic [sskmv_pkg::HASH_W-1:0] v);
        bucket_result_t res;
        int unsigned    b;
        int unsigned    base;
        int unsigned    k;
        int unsigned    n;
        int unsigned    i;
        int unsigned    p;
        int unsigned    lvl;
        logic           dup;
        logic [63:0]    q;
        b = r * sskmv_pkg::COLUMNS + c;
        base = b * sskmv_pkg::K_MAX;
        k = eff_size();
        res = '0;
        if (f == FUNC_UPDATE)
        begin
            lvl = 0;
            while (lvl < 64 && e[lvl])
            begin
                lvl++;
            end
            if (lvl_mem[b] < lvl)
            begin
                lvl_mem[b] = sskmv_pkg::LVL_W'(lvl);
                key_mem[b] = src;
            end
            n = (fill_mem[b] > sskmv_pkg::K_MAX) ? sskmv_pkg::K_MAX : fill_mem[b];
            dup = 1'b0;
            for (i = 0; i < n; i++)
            begin
                if (min_list[base+i] == v)
                begin
                    dup = 1'b1;
                end
            end
            if (!(n >= k && min_list[base] <= v) && !dup)
            begin
                res.inserted = 1'b1;
                if (n >= k)
                begin
                    // Full list: drop the head and slide the value into place.
                    i = 0;
                    while (i + 1 < n && min_list[base+i+1] > v)
                    begin
                        min_list[base+i] = min_list[base+i+1];
                        i++;
                    end
                    min_list[base+i] = v;
                end
                else
                begin
                    p = 0;
                    while (p < n && min_list[base+p] > v)
                    begin
                        p++;
                    end
                    for (i = n; i > p; i--)
                    begin
                        min_list[base+i] = min_list[base+i-1];
                    end
                    min_list[base+p] = v;
                    fill_mem[b] = n + 1;
                end
            end
        end
        // Estimate from fill, or from the head once the list is full.
        if (fill_mem[b] < k)
        begin
            res.estimate = sskmv_pkg::EST_W'(fill_mem[b]);
        end
        else if (min_list[base] == '0)
        begin
            res.estimate = sskmv_pkg::EST_SAT;
        end
        else
        begin
            q = (64'((k > 1) ? k - 1 : 1) * 64'hFFFF_FFFF) / 64'(min_list[base]);
            res.estimate = (q > 64'h7FFF_FFFF) ? sskmv_pkg::EST_SAT : q[sskmv_pkg::EST_W-1:0];
        end
        res.key = key_mem[b];
        res.level = lvl_mem[b];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Sends one word, at times with a random gap ahead of it.
    task automatic send_word(input logic f, input logic [sskmv_pkg::ROW_W-1:0] r,
                             input logic [sskmv_pkg::COL_W-1:0] c,
                             input logic [sskmv_pkg::KEY_W-1:0] src,
                             input logic [sskmv_pkg::EDGE_W-1:0] e,
                             input logic [sskmv_pkg::HASH_W-1:0] v);
        int gap;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        row       <= r;
        column    <= c;
        src_key   <= src;
        edge_hash <= e;
        dst_hash  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_results = {pending_results, bucket_model_step(f, r, c, src, e, v)};
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Writes the list size once every result is back and the block is quiet.
    task automatic write_list_size(input logic [sskmv_pkg::CFG_W-1:0] value);
        stop_sending();
        wait (pending_results.size() == 0);
        repeat (130) @(negedge clk);
        cfg_valid <= 1'b1;
        kmv_size  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        list_size = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Edge hash with a chosen number of trailing ones and random upper bits.
    function automatic logic [sskmv_pkg::EDGE_W-1:0] edge_with_level(input int n);
        logic [sskmv_pkg::EDGE_W-1:0] e;
        e = {$urandom, $urandom};
        if (n >= 64)
        begin
            return '1;
        end
        for (int i = 0; i < n; i++)
        begin
            e[i] = 1'b1;
        end
        e[n] = 1'b0;
        return e;
    endfunction

    // Receiver readiness, redrawn every cycle.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        bucket_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", 64'(estimate), 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (estimate !== want.estimate)
                begin
                    report_mismatch("estimate", 64'(estimate), 64'(want.estimate));
                end
                if (bucket_key !== want.key)
                begin
                    report_mismatch("bucket_key", 64'(bucket_key), 64'(want.key));
                end
                if (bucket_level !== want.level)
                begin
                    report_mismatch("bucket_level", 64'(bucket_level), 64'(want.level));
                end
                if (value_inserted !== want.inserted)
                begin
                    report_mismatch("value_inserted", 64'(value_inserted), 64'(want.inserted));
                end
            end
        end
    end

    // Extremes of the fields, saturation, duplicates and a full list.
    task automatic test_directed();
        send_word(FUNC_UPDATE, 2'd0, 10'd0, 32'h0, 64'h0, 32'hFFFF_FFFF);
        send_word(FUNC_PROBE, 2'd0, 10'd0, 32'hFFFF_FFFF, '1, 32'h0);
        send_word(FUNC_UPDATE, 2'd0, 10'd0, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);
        send_word(FUNC_UPDATE, 2'd3, 10'd1023, 32'hA5A5_5A5A, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
        send_word(FUNC_UPDATE, 2'd3, 10'd1023, 32'h1234_5678, edge_with_level(5),
                  32'h8000_0000);
        send_word(FUNC_PROBE, 2'd3, 10'd1023, 32'h0, 64'h0, 32'h0);
        write_list_size(6'd1);
        send_word(FUNC_UPDATE, 2'd1, 10'd5, 32'h1, edge_with_level(1), 32'h0);
        send_word(FUNC_UPDATE, 2'd1, 10'd5, 32'h2, edge_with_level(2), 32'h5);
        send_word(FUNC_UPDATE, 2'd1, 10'd6, 32'h3, edge_with_level(0), 32'hFFFF_FFFF);
        send_word(FUNC_UPDATE, 2'd1, 10'd6, 32'h4, edge_with_level(3), 32'h7);
        send_word(FUNC_UPDATE, 2'd1, 10'd6, 32'h5, edge_with_level(3), 32'h7);
        send_word(FUNC_PROBE, 2'd1, 10'd6, 32'h0, 64'h0, 32'h0);
        send_word(FUNC_UPDATE, 2'd0, 10'd0, 32'h6, edge_with_level(2), 32'h10);
        write_list_size(6'd2);
        send_word(FUNC_UPDATE, 2'd2, 10'd512, 32'h7, edge_with_level(63), 32'h3);
        send_word(FUNC_UPDATE, 2'd2, 10'd512, 32'h8, edge_with_level(4), 32'h1);
        send_word(FUNC_UPDATE, 2'd2, 10'd512, 32'h9, edge_with_level(4), 32'h2);
        send_word(FUNC_UPDATE, 2'd2, 10'd512, 32'hA, edge_with_level(4), 32'h9);
    endtask

    // Random words aimed mostly at a few hot buckets so their lists fill.
    task automatic test_random(input logic [sskmv_pkg::CFG_W-1:0] size, input int count);
        logic [sskmv_pkg::ROW_W-1:0]  r;
        logic [sskmv_pkg::COL_W-1:0]  c;
        logic [sskmv_pkg::HASH_W-1:0] v;
        logic                         f;
        int                           pick;
        write_list_size(size);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                r = sskmv_pkg::ROW_W'(pick % 4);
                c = (pick < 4) ? sskmv_pkg::COL_W'(1023 - pick) : sskmv_pkg::COL_W'(pick);
            end
            else
            begin
                r = sskmv_pkg::ROW_W'($urandom);
                c = sskmv_pkg::COL_W'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick < 5)
            begin
                v = $urandom_range(0, 40);
            end
            else if (pick == 5)
            begin
                v = 32'hFFFF_FFFF;
            end
            else
            begin
                v = $urandom;
            end
            f = ($urandom_range(0, 4) == 0) ? FUNC_PROBE : FUNC_UPDATE;
            send_word(f, r, c, $urandom, edge_with_level($urandom_range(0, 66)), v);
        end
    endtask

    initial
    begin
        error_count   = 0;
        send_idle_pct = 17;
        recv_idle_pct = 59;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = 1'b0;
        row           = '0;
        column        = '0;
        src_key       = '0;
        edge_hash     = '0;
        dst_hash      = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        kmv_size      = '0;
        list_size     = sskmv_pkg::KMV_SIZE_RESET;
        for (int i = 0; i < sskmv_pkg::BUCKETS; i++)
        begin
            lvl_mem[i]  = '0;
            key_mem[i]  = '0;
            fill_mem[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(6'd3, 120);
        test_random(6'd32, 130);
        send_idle_pct = 59;
        recv_idle_pct = 17;
        test_random(6'd63, 130);
        test_random(6'd1, 120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(6'd0, 100);
        test_random(6'd5, 100);
        test_random(6'd32, 60);

        stop_sending();
        wait (pending_results.size() == 0);
        repeat (150) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sskmv_pkg.sv
rtl/sskmv_ram.sv
rtl/sskmv_div.sv
rtl/spread_sketch_kmv_update.sv
bench/spread_sketch_kmv_update_tb.sv
